// ===== hw/rtl/wss_pkg.sv =====
// Package: configuration register indexes and port widths for window sample statistics.
`default_nettype none
package wss_pkg;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_RECORD       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAST_RECORD        = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLES_PER_RECORD = 2'd2;
   localparam int RECORD_BITS = 16;
   localparam int SPR_BITS    = 9;
   localparam int SPR_LIMIT   = 256;
   localparam int WINDOW_BITS = RECORD_BITS + 1 + SPR_BITS;
endpackage
`default_nettype wire

// ===== hw/rtl/window_sample_statistics.sv =====
// Top level: windowed count, minimum, maximum, mean, variance and std deviation of samples.
//
// Request channel: req_sample and req_last are taken at a rising edge with start high and
// busy low. A sample passes through three steps (capture, square, accumulate) and busy
// stays high meanwhile, so no new sample is taken before the last one is done.
// A sample outside the record window is counted in the position only.
// On a sample with req_last high, one result follows on the rsp_ ports, marked by rsp_valid
// for exactly one cycle. The result is computed by one shift-add multiplier run three
// times for (S+C) steps each, one restoring divider run twice for (2S+2C) steps each and a
// digit-by-digit square root of S steps, S = SAMPLE_BITS and C = COUNT_LOG2. An empty
// window gives its result after the accumulate, with rsp_empty_res high and all other
// fields zero.
// The receiver cannot stall: each result is shown once and must be taken then.
// Configuration: csr_we writes csr_wdata into register csr_index; write only while busy
// is low. Reset (synchronous, active high) sets the register defaults and clears all
// running statistics.
`default_nettype none
module window_sample_statistics #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_LOG2  = 24
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     start,
   output logic                                    busy,
   input  wire  signed [SAMPLE_BITS-1:0]           req_sample,
   input  wire                                     req_last,
   input  wire                                     csr_we,
   input  wire  [wss_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire  [wss_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   output logic                                    rsp_valid,
   output logic [COUNT_LOG2:0]                     rsp_count,
   output logic signed [SAMPLE_BITS-1:0]           rsp_minimum,
   output logic signed [SAMPLE_BITS-1:0]           rsp_maximum,
   output logic signed [SAMPLE_BITS-1:0]           rsp_mean,
   output logic [2*SAMPLE_BITS-2:0]                rsp_variance,
   output logic [SAMPLE_BITS-1:0]                  rsp_std_dev,
   output logic                                    rsp_empty_res
);
   localparam int S    = SAMPLE_BITS;
   localparam int C    = COUNT_LOG2;
   localparam int NB   = C + 1;
   localparam int SUMW = S + C;
   localparam int SQW  = 2 * S + C - 1;
   localparam int NW   = 2 * S + 2 * C;
   localparam int MBW  = S + C;
   localparam int DENW = 2 * C + 2;
   localparam int DW   = DENW + 1;
   localparam int VW   = 2 * S - 1;
   localparam int CW   = $clog2(NW + 1);
   localparam int WB   = wss_pkg::WINDOW_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_SQRT = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [wss_pkg::RECORD_BITS-1:0] first_ff, last_ff;
   logic [wss_pkg::SPR_BITS-1:0]    spr_ff;

   logic signed [S-1:0] smp_ff;
   logic                last_req_ff;
   logic [S-1:0]        mag_ff;
   logic                win_ff;
   logic [2*S-1:0]      sq_ff;

   logic [NB-1:0]         pos_ff, pos_in;
   logic [NB-1:0]         kept_ff, kept_in;
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [SQW-1:0]        sumsq_ff, sumsq_in;
   logic signed [S-1:0]   min_ff, min_in, max_ff, max_in;

   logic [NW-1:0]   mula_ff, mula_in, acc_ff, acc_in, acc_step;
   logic [MBW-1:0]  mulb_ff, mulb_in;
   logic [NW-1:0]   num_ff, num_in;
   logic [DENW-1:0] den_ff, den_in, dsr_ff, dsr_in;
   logic [NW-1:0]   dvd_ff, dvd_in, quo_ff, quo_in, quo_step;
   logic [DW-1:0]   rem_ff, rem_in, rem_try;
   logic            rem_ge;
   logic signed [S-1:0] mean_ff, mean_in;
   logic [VW-1:0]   var_ff, var_in;
   logic [2*S-1:0]  sv_ff, sv_in;
   logic [S+1:0]    srem_ff, srem_in, srem_try, strial;
   logic            s_ge;
   logic [S-1:0]    root_ff, root_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [NB-1:0]   rcount_ff, rcount_in;
   logic signed [S-1:0] rmin_ff, rmin_in, rmax_ff, rmax_in, rmean_ff, rmean_in;
   logic [VW-1:0]   rvar_ff, rvar_in;
   logic [S-1:0]    rstd_ff, rstd_in;
   logic            rempty_ff, rempty_in;

   logic [wss_pkg::SPR_BITS-1:0] spr_eff;
   logic [WB-1:0]   lo_pos, hi_pos, pos_ext;
   logic            win_now, accept;
   logic            sum_neg;
   logic [SUMW-1:0] smag;
   logic [S-1:0]    mean_mag;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign spr_eff = (spr_ff > wss_pkg::SPR_BITS'(wss_pkg::SPR_LIMIT)) ?
                    wss_pkg::SPR_BITS'(wss_pkg::SPR_LIMIT) : spr_ff;
   assign lo_pos  = WB'(first_ff) * WB'(spr_eff);
   assign hi_pos  = (WB'(last_ff) + WB'(1)) * WB'(spr_eff);
   assign pos_ext = WB'(pos_ff);
   assign win_now = (pos_ext >= lo_pos) && (pos_ext < hi_pos) && !kept_ff[C];

   assign sum_neg  = sum_ff[SUMW-1];
   assign smag     = sum_neg ? SUMW'(-sum_ff) : SUMW'(sum_ff);
   assign acc_step = acc_ff + (mulb_ff[0] ? mula_ff : NW'(0));
   assign rem_try  = {rem_ff[DW-2:0], dvd_ff[NW-1]};
   assign rem_ge   = rem_try >= {1'b0, dsr_ff};
   assign quo_step = {quo_ff[NW-2:0], rem_ge};
   assign mean_mag = quo_step[S-1:0];
   assign srem_try = {srem_ff[S-1:0], sv_ff[2*S-1:2*S-2]};
   assign strial   = {root_ff, 2'b01};
   assign s_ge     = srem_try >= strial;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      kept_in  = kept_ff;
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      mula_in  = mula_ff;
      mulb_in  = mulb_ff;
      acc_in   = acc_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      dsr_in   = dsr_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      mean_in  = mean_ff;
      var_in   = var_ff;
      sv_in    = sv_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      rsp_valid_in = 1'b0;
      rcount_in = rcount_ff;
      rmin_in   = rmin_ff;
      rmax_in   = rmax_ff;
      rmean_in  = rmean_ff;
      rvar_in   = rvar_ff;
      rstd_in   = rstd_ff;
      rempty_in = rempty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (win_ff) begin
               kept_in  = kept_ff + NB'(1);
               sum_in   = sum_ff + SUMW'(smp_ff);
               sumsq_in = sumsq_ff + SQW'(sq_ff);
               if (smp_ff < min_ff) begin
                  min_in = smp_ff;
               end
               if (smp_ff > max_ff) begin
                  max_in = smp_ff;
               end
            end
            if (pos_ff != {NB{1'b1}}) begin
               pos_in = pos_ff + NB'(1);
            end
            state_in = last_req_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (kept_ff == NB'(0)) begin
               mean_in  = '0;
               var_in   = '0;
               root_in  = '0;
               state_in = ST_OUT;
            end else begin
               mula_in  = NW'(sumsq_ff);
               mulb_in  = MBW'(kept_ff);
               acc_in   = '0;
               phase_in = 2'd0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in  = acc_step;
            mula_in = {mula_ff[NW-2:0], 1'b0};
            mulb_in = {1'b0, mulb_ff[MBW-1:1]};
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MBW - 1)) begin
               cnt_in = '0;
               acc_in = '0;
               case (phase_ff)
                  2'd0: begin
                     num_in   = acc_step;
                     mula_in  = NW'(smag);
                     mulb_in  = MBW'(smag);
                     phase_in = 2'd1;
                  end
                  2'd1: begin
                     num_in   = num_ff - acc_step;
                     mula_in  = NW'(kept_ff);
                     mulb_in  = MBW'(kept_ff);
                     phase_in = 2'd2;
                  end
                  default: begin
                     den_in   = acc_step[DENW-1:0];
                     dvd_in   = NW'(smag);
                     dsr_in   = DENW'(kept_ff);
                     rem_in   = '0;
                     quo_in   = '0;
                     phase_in = 2'd0;
                     state_in = ST_DIV;
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? (rem_try - {1'b0, dsr_ff}) : rem_try;
            quo_in = quo_step;
            dvd_in = {dvd_ff[NW-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               quo_in = '0;
               if (phase_ff == 2'd0) begin
                  mean_in  = sum_neg ? S'(-mean_mag) : mean_mag;
                  dvd_in   = num_ff;
                  dsr_in   = den_ff;
                  phase_in = 2'd1;
               end else begin
                  var_in   = quo_step[VW-1:0];
                  sv_in    = {1'b0, quo_step[VW-1:0]};
                  srem_in  = '0;
                  root_in  = '0;
                  state_in = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            srem_in = s_ge ? (srem_try - strial) : srem_try;
            root_in = {root_ff[S-2:0], s_ge};
            sv_in   = {sv_ff[2*S-3:0], 2'b00};
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(S - 1)) begin
               cnt_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            rempty_in = (kept_ff == NB'(0));
            rcount_in = kept_ff;
            rmin_in   = rempty_in ? S'(0) : min_ff;
            rmax_in   = rempty_in ? S'(0) : max_ff;
            rmean_in  = mean_ff;
            rvar_in   = var_ff;
            rstd_in   = root_ff;
            pos_in    = '0;
            kept_in   = '0;
            sum_in    = '0;
            sumsq_in  = '0;
            min_in    = {1'b0, {(S-1){1'b1}}};
            max_in    = {1'b1, {(S-1){1'b0}}};
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         first_ff     <= '0;
         last_ff      <= '1;
         spr_ff       <= wss_pkg::SPR_BITS'(1);
         pos_ff       <= '0;
         kept_ff      <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         min_ff       <= {1'b0, {(S-1){1'b1}}};
         max_ff       <= {1'b1, {(S-1){1'b0}}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         kept_ff      <= kept_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               wss_pkg::CSR_FIRST_RECORD:       first_ff <= csr_wdata;
               wss_pkg::CSR_LAST_RECORD:        last_ff  <= csr_wdata;
               wss_pkg::CSR_SAMPLES_PER_RECORD: spr_ff   <= csr_wdata[wss_pkg::SPR_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff      <= req_sample;
         last_req_ff <= req_last;
         mag_ff      <= req_sample[S-1] ? S'(-req_sample) : S'(req_sample);
         win_ff      <= win_now;
      end
      sq_ff     <= mag_ff * mag_ff;
      mula_ff   <= mula_in;
      mulb_ff   <= mulb_in;
      acc_ff    <= acc_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      dsr_ff    <= dsr_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      mean_ff   <= mean_in;
      var_ff    <= var_in;
      sv_ff     <= sv_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      rcount_ff <= rcount_in;
      rmin_ff   <= rmin_in;
      rmax_ff   <= rmax_in;
      rmean_ff  <= rmean_in;
      rvar_ff   <= rvar_in;
      rstd_ff   <= rstd_in;
      rempty_ff <= rempty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_count     = rcount_ff;
   assign rsp_minimum   = rmin_ff;
   assign rsp_maximum   = rmax_ff;
   assign rsp_mean      = rmean_ff;
   assign rsp_variance  = rvar_ff;
   assign rsp_std_dev   = rstd_ff;
   assign rsp_empty_res = rempty_ff;

`ifndef SYNTHESIS
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while busy");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_empty_res) |-> (rsp_count == '0 && rsp_variance == '0))
      else $error("empty result carries data");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not held");
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
`endif
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for window_sample_statistics: directed and random sample streams checked against a predictor.
`timescale 1ns / 1ps
module tb;
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_LOG2  = 24;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [COUNT_LOG2:0]           count;
      logic signed [SAMPLE_BITS-1:0] minimum;
      logic signed [SAMPLE_BITS-1:0] maximum;
      logic signed [SAMPLE_BITS-1:0] mean;
      logic [2*SAMPLE_BITS-2:0]      variance;
      logic [SAMPLE_BITS-1:0]        std_dev;
      logic                          empty_res;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic req_last = 1'b0;
   logic csr_we = 1'b0;
   logic [wss_pkg::CSR_INDEX_BITS-1:0] csr_index = wss_pkg::CSR_FIRST_RECORD;
   logic [wss_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic [COUNT_LOG2:0] rsp_count;
   logic signed [SAMPLE_BITS-1:0] rsp_minimum, rsp_maximum, rsp_mean;
   logic [2*SAMPLE_BITS-2:0] rsp_variance;
   logic [SAMPLE_BITS-1:0] rsp_std_dev;
   logic rsp_empty_res;

   window_sample_statistics #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_LOG2(COUNT_LOG2)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_sample(req_sample), .req_last(req_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_count(rsp_count), .rsp_minimum(rsp_minimum),
      .rsp_maximum(rsp_maximum), .rsp_mean(rsp_mean), .rsp_variance(rsp_variance),
      .rsp_std_dev(rsp_std_dev), .rsp_empty_res(rsp_empty_res)
   );

   // window settings and running statistics of the predictor
   longint unsigned win_first, win_last, win_spr;
   longint unsigned pos, kept;
   longint          sum_acc;
   longint unsigned sumsq_acc;
   longint          min_acc, max_acc;

   stats_type expected_stats[$];
   int gap_pct = 0;
   int requests = 0, results = 0, mismatches = 0;
   int stall_cycles = 0;
   bit failed = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [SAMPLE_BITS-1:0] floor_sqrt(logic [2*SAMPLE_BITS-2:0] v);
      logic [SAMPLE_BITS-1:0] r;
      logic [SAMPLE_BITS-1:0] t;
      r = '0;
      for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
         t = r | (SAMPLE_BITS'(1) << b);
         if (64'(t) * 64'(t) <= 64'(v)) r = t;
      end
      return r;
   endfunction

   function automatic void clear_stats();
      pos = 0;
      kept = 0;
      sum_acc = 0;
      sumsq_acc = 0;
      min_acc = 32767;
      max_acc = -32768;
   endfunction

   function automatic void accumulate_sample(logic signed [SAMPLE_BITS-1:0] s, logic is_last);
      longint unsigned spr, lo, hi, mag;
      longint v;
      logic [127:0] num;
      logic [127:0] quot;
      longint mean_full;
      stats_type e;
      spr = (win_spr > 256) ? 256 : win_spr;
      lo = win_first * spr;
      hi = (win_last + 1) * spr;
      v = 64'(s);
      if (pos >= lo && pos < hi && kept < (64'd1 << COUNT_LOG2)) begin
         mag = (v < 0) ? -v : v;
         kept++;
         sum_acc += v;
         sumsq_acc += mag * mag;
         if (v < min_acc) min_acc = v;
         if (v > max_acc) max_acc = v;
      end
      if (pos < (64'd1 << (COUNT_LOG2 + 1)) - 1) pos++;
      if (!is_last) return;
      e = '0;
      if (kept == 0) begin
         e.empty_res = 1'b1;
      end else begin
         mag = (sum_acc < 0) ? -sum_acc : sum_acc;
         num = 128'(kept) * 128'(sumsq_acc) - 128'(mag) * 128'(mag);
         quot = num / (128'(kept) * 128'(kept));
         mean_full = sum_acc / longint'(kept);
         e.count = kept[COUNT_LOG2:0];
         e.minimum = min_acc[SAMPLE_BITS-1:0];
         e.maximum = max_acc[SAMPLE_BITS-1:0];
         e.mean = mean_full[SAMPLE_BITS-1:0];
         e.variance = quot[2*SAMPLE_BITS-2:0];
         e.std_dev = floor_sqrt(e.variance);
      end
      expected_stats.push_back(e);
      clear_stats();
   endfunction

   always @(posedge clock) begin
      stats_type e;
      stats_type got;
      if (!reset && rsp_valid) begin
         results++;
         got = {rsp_count, rsp_minimum, rsp_maximum, rsp_mean, rsp_variance, rsp_std_dev,
                rsp_empty_res};
         if (expected_stats.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %p", got);
         end else begin
            e = expected_stats.pop_front();
            if (got != e) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired");
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic is_last);
      start <= 1'b1;
      req_sample <= s;
      req_last <= is_last;
      do @(posedge clock); while (busy);
      requests++;
      accumulate_sample(s, is_last);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // drop start and wait until every expected result has come
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_stats.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic set_window(logic [15:0] first, logic [15:0] last_rec, logic [15:0] spr);
      drain();
      csr_we <= 1'b1;
      csr_index <= wss_pkg::CSR_FIRST_RECORD;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= wss_pkg::CSR_LAST_RECORD;
      csr_wdata <= last_rec;
      @(posedge clock);
      csr_index <= wss_pkg::CSR_SAMPLES_PER_RECORD;
      csr_wdata <= spr;
      @(posedge clock);
      csr_we <= 1'b0;
      win_first = 64'(first);
      win_last = 64'(last_rec);
      win_spr = 64'(spr[8:0]);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return SAMPLE_BITS'($urandom_range(0, 20)) - SAMPLE_BITS'(10);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic test_default_window();
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sd5, 1'b0);
      send_sample(-16'sd8, 1'b1);
      drain();
   endtask

   task automatic test_empty_windows();
      set_window(16'd3, 16'd2, 16'd1);
      send_sample(16'sd100, 1'b0);
      send_sample(16'sd7, 1'b0);
      send_sample(-16'sd7, 1'b0);
      send_sample(16'sd100, 1'b1);
      set_window(16'd0, 16'd65535, 16'd0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b1);
      set_window(16'hFFFF, 16'hFFFF, 16'h0001);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd2, 1'b1);
      set_window(16'd1, 16'd2, 16'd2);
      send_sample(16'sd9, 1'b0);
      send_sample(16'sd9, 1'b0);
      send_sample(16'sd3, 1'b0);
      send_sample(-16'sd4, 1'b0);
      send_sample(16'sd6, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(16'sd9, 1'b1);
      drain();
   endtask

   task automatic test_record_size_saturation();
      set_window(16'd0, 16'd0, 16'hFFFF);
      for (int i = 0; i < 260; i++) send_sample(pick_sample(), i == 259);
      drain();
   endtask

   task automatic test_random_windows(int n_requests);
      int sent;
      int len;
      logic [15:0] first;
      sent = 0;
      while (sent < n_requests) begin
         gap_pct = (sent / 100) % 3 == 0 ? 0 : ((sent / 100) % 3 == 1 ? 53 : 8);
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
               0: set_window(16'($urandom), 16'($urandom), 16'($urandom));
               1: set_window(16'd0, 16'hFFFF, 16'($urandom_range(1, 256)));
               default: begin
                  first = 16'($urandom_range(0, 3));
                  set_window(first, first + 16'($urandom_range(0, 3)),
                             16'($urandom_range(0, 6)));
               end
            endcase
         end
         len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
         sent += len;
      end
      gap_pct = 0;
      drain();
   endtask

   initial begin
      win_first = 0;
      win_last = 65535;
      win_spr = 1;
      clear_stats();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_window();
      test_empty_windows();
      test_record_size_saturation();
      test_random_windows(360);
      repeat (400) @(posedge clock);
      if (expected_stats.size() != 0) begin
         failed = 1;
         $display("%0d expected results never arrived", expected_stats.size());
      end
      $display("Sent %0d samples, checked %0d results over several record windows,",
               requests, results);
      $display("empty and saturated windows, and idle rates of 0, 8 and 53 percent.");
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/wss_pkg.sv
hw/rtl/window_sample_statistics.sv
test/tb.sv
